/* sv/bmh_pkg.sv */
// ----------------------------------------------------------------------------
// bmh_pkg: shared types and constants for the binary min-heap
// Key type, operation and status codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

   localparam int CAPACITY_DEFAULT = 1024;

   localparam int KEY_W       = 32;
   localparam int FUNC_W      = 3;
   localparam int POS_W       = 10;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 11;

   typedef logic signed [KEY_W-1:0] key_type;

   localparam key_type KEY_MAX = 32'sh7FFF_FFFF;
   localparam key_type KEY_MIN = 32'sh8000_0000;

   // operation codes carried by a request beat
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT   = 3'd0,
      FUNC_EXTRACT  = 3'd1,
      FUNC_DELETE   = 3'd2,
      FUNC_DECREASE = 3'd3,
      FUNC_INCREASE = 3'd4
   } func_type;

   // status codes carried by a response beat
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      STATE_IDLE,
      STATE_UP_RD,
      STATE_UP_CMP,
      STATE_EX_RD_ROOT,
      STATE_EX_RD_LAST,
      STATE_EX_CAP,
      STATE_DN_RD_L,
      STATE_DN_RD_R,
      STATE_DN_CMP,
      STATE_DONE
   } state_type;

endpackage

`default_nettype wire

/* sv/bmh_mem.sv */
// ----------------------------------------------------------------------------
// bmh_mem: key storage for the heap
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_mem #(
   parameter int DEPTH = bmh_pkg::CAPACITY_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire bmh_pkg::key_type wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output bmh_pkg::key_type      rd_data
);
   import bmh_pkg::*;

   key_type mem_ff [DEPTH];
   key_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/bmh_ctrl.sv */
// ----------------------------------------------------------------------------
// bmh_ctrl: heap sequencer
// Holds the moving key in a register and walks the tree one level at a time,
// reading children or parent from the key memory and writing back displaced
// entries; the moving key is written once where it comes to rest.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ctrl #(
   parameter int CAPACITY = bmh_pkg::CAPACITY_DEFAULT,
   parameter int AW       = $clog2(CAPACITY),
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [bmh_pkg::FUNC_W-1:0]    req_func,
   input  wire bmh_pkg::key_type              req_key_value,
   input  wire logic [bmh_pkg::POS_W-1:0]     req_position,
   // response channel
   output logic                               rsp_strobe,
   output bmh_pkg::key_type                   rsp_min_value,
   output logic [bmh_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bmh_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   // key memory
   output logic                               mem_wr_en,
   output logic [AW-1:0]                      mem_wr_addr,
   output bmh_pkg::key_type                   mem_wr_data,
   output logic                               mem_rd_en,
   output logic [AW-1:0]                      mem_rd_addr,
   input  wire bmh_pkg::key_type              mem_rd_data
);
   import bmh_pkg::*;

   localparam int IW = AW + 2;   // child index width, holds 2*at+2

   state_type        state_ff,  state_in;
   logic [CW-1:0]    count_ff,  count_in;
   func_type         op_ff,     op_in;
   key_type          key_ff,    key_in;
   logic [AW-1:0]    at_ff,     at_in;
   key_type          min_ff,    min_in;
   status_type       status_ff, status_in;
   key_type          left_ff,   left_in;
   logic             rc_ok_ff,  rc_ok_in;

   logic [IW-1:0]    left_idx;
   logic [IW-1:0]    right_idx;
   logic [IW-1:0]    count_ext;
   logic [AW-1:0]    parent_idx;
   logic             pos_range;
   logic             dn_take_left;
   logic             dn_take_right;
   key_type          dn_best;

   assign left_idx   = {1'b0, at_ff, 1'b1};
   assign right_idx  = left_idx + IW'(1);
   assign count_ext  = IW'(count_ff);
   assign parent_idx = AW'((at_ff - AW'(1)) >> 1);
   assign pos_range  = 32'(req_position) >= 32'(count_ff);

   // sift-down child choice: strictly smaller wins, left child on ties
   always_comb begin
      dn_take_left  = left_ff < key_ff;
      dn_best       = dn_take_left ? left_ff : key_ff;
      dn_take_right = rc_ok_ff && (mem_rd_data < dn_best);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      at_ff     <= at_in;
      min_ff    <= min_in;
      status_ff <= status_in;
      left_ff   <= left_in;
      rc_ok_ff  <= rc_ok_in;
   end

   // next state and memory control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      at_in       = at_ff;
      min_in      = min_ff;
      status_in   = status_ff;
      left_in     = left_ff;
      rc_ok_in    = rc_ok_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = at_ff;
      mem_wr_data = key_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               op_in     = func_type'(req_func);
               key_in    = req_key_value;
               min_in    = '0;
               status_in = STAT_OK;
               state_in  = STATE_DONE;
               case (func_type'(req_func))
                  FUNC_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        at_in    = AW'(count_ff);
                        count_in = CW'(count_ff + CW'(1));
                        state_in = STATE_UP_RD;
                     end
                  end
                  FUNC_EXTRACT: begin
                     if (count_ff == '0) begin
                        min_in    = KEY_MAX;
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = STATE_EX_RD_ROOT;
                     end
                  end
                  FUNC_DELETE: begin
                     if (pos_range) begin
                        status_in = STAT_RANGE;
                     end else begin
                        key_in   = KEY_MIN;
                        at_in    = AW'(req_position);
                        state_in = STATE_UP_RD;
                     end
                  end
                  FUNC_DECREASE: begin
                     if (pos_range) begin
                        status_in = STAT_RANGE;
                     end else begin
                        at_in    = AW'(req_position);
                        state_in = STATE_UP_RD;
                     end
                  end
                  FUNC_INCREASE: begin
                     if (pos_range) begin
                        status_in = STAT_RANGE;
                     end else begin
                        at_in    = AW'(req_position);
                        state_in = STATE_DN_RD_L;
                     end
                  end
                  default: begin
                     state_in = STATE_DONE;
                  end
               endcase
            end
         end

         // sift up: fetch parent, or settle at the root
         STATE_UP_RD: begin
            if (at_ff == '0) begin
               mem_wr_en = 1'b1;
               state_in  = (op_ff == FUNC_DELETE) ? STATE_EX_RD_ROOT : STATE_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = parent_idx;
               state_in    = STATE_UP_CMP;
            end
         end

         // sift up: move a larger parent down, else settle here
         STATE_UP_CMP: begin
            mem_wr_en = 1'b1;
            if (mem_rd_data > key_ff) begin
               mem_wr_data = mem_rd_data;
               at_in       = parent_idx;
               state_in    = STATE_UP_RD;
            end else begin
               state_in = (op_ff == FUNC_DELETE) ? STATE_EX_RD_ROOT : STATE_DONE;
            end
         end

         // pop: read root, then last entry
         STATE_EX_RD_ROOT: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_in    = STATE_EX_RD_LAST;
         end

         STATE_EX_RD_LAST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(count_ff - CW'(1));
            if (op_ff == FUNC_EXTRACT) begin
               min_in = mem_rd_data;
            end
            state_in = STATE_EX_CAP;
         end

         // pop: last entry becomes the moving key at the root
         STATE_EX_CAP: begin
            key_in   = mem_rd_data;
            at_in    = '0;
            count_in = CW'(count_ff - CW'(1));
            state_in = (count_ff == CW'(1)) ? STATE_DONE : STATE_DN_RD_L;
         end

         // sift down: fetch left child, or settle at a leaf
         STATE_DN_RD_L: begin
            if (left_idx >= count_ext) begin
               mem_wr_en = 1'b1;
               state_in  = STATE_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(left_idx);
               state_in    = STATE_DN_RD_R;
            end
         end

         // sift down: capture left, fetch right if present
         STATE_DN_RD_R: begin
            left_in  = mem_rd_data;
            rc_ok_in = right_idx < count_ext;
            if (right_idx < count_ext) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(right_idx);
            end
            state_in = STATE_DN_CMP;
         end

         // sift down: lift the smaller child, or settle here
         STATE_DN_CMP: begin
            mem_wr_en = 1'b1;
            if (dn_take_right) begin
               mem_wr_data = mem_rd_data;
               at_in       = AW'(right_idx);
               state_in    = STATE_DN_RD_L;
            end else if (dn_take_left) begin
               mem_wr_data = left_ff;
               at_in       = AW'(left_idx);
               state_in    = STATE_DN_RD_L;
            end else begin
               state_in = STATE_DONE;
            end
         end

         STATE_DONE: begin
            state_in = STATE_IDLE;
         end

         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // channel outputs
   assign busy            = state_ff != STATE_IDLE;
   assign rsp_strobe      = state_ff == STATE_DONE;
   assign rsp_min_value   = min_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = COUNT_OUT_W'(count_ff);

endmodule

`default_nettype wire

/* sv/binary_min_heap.sv */
// ----------------------------------------------------------------------------
// binary_min_heap: array-backed min-heap of signed 32-bit keys
// Insert, extract-min, delete at index, decrease and increase key.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_func, req_key_value, req_position) is taken on a
//   clock edge where start is high and busy is low. busy stays high until
//   the single response beat has been shown. The response (rsp_min_value,
//   rsp_status, rsp_entry_count) stands for exactly one cycle, marked by
//   rsp_strobe; the receiver must take it then, it cannot stall the block.
//   One operation is in flight at a time.
// Operation steps: flagged or unused operations go straight to the response.
// Climbing costs a parent read and a compare per level, sinking two child
// reads and a compare; at most log2(CAPACITY) levels are moved. Extract-min
// first reads the root and the last entry; delete sifts a KEY_MIN key up,
// then pops the root. busy drops the cycle after the strobe.
// Reset (synchronous, active high) empties the heap; the key memory is not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap #(
   parameter int CAPACITY = bmh_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [bmh_pkg::FUNC_W-1:0]    req_func,
   input  wire bmh_pkg::key_type              req_key_value,
   input  wire logic [bmh_pkg::POS_W-1:0]     req_position,
   output logic                               rsp_strobe,
   output bmh_pkg::key_type                   rsp_min_value,
   output logic [bmh_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bmh_pkg::COUNT_OUT_W-1:0]    rsp_entry_count
);
   import bmh_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   key_type         mem_wr_data;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   key_type         mem_rd_data;

   // sequencer
   bmh_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key_value   (req_key_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_min_value   (rsp_min_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   // key storage
   bmh_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // response beat only comes out of a running operation, then it goes idle
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response beat outside an operation");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("block did not return to idle after response");

   // an accepted request always starts an operation
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start an operation");

   // sequencer never reads and writes the same entry in one cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
      else $error("read and write of the same entry in one cycle");

   // full is flagged only at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STAT_FULL)) |->
         (rsp_entry_count == COUNT_OUT_W'(CAPACITY)))
      else $error("full status below capacity");

endmodule

`default_nettype wire

/* tb/binary_min_heap_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_test: self-checking bench for the binary min-heap
// A mirror heap predicts each response beat from the accepted requests.
// Directed corner beats come first. Random traffic follows, then a drain to
// empty back to back. The monitor checks every strobed response against the
// oldest prediction.
// ----------------------------------------------------------------------------

module binary_min_heap_test;
   import bmh_pkg::*;

   localparam int CAPACITY = CAPACITY_DEFAULT;
   localparam int MAX_REPORTS = 10;
   // codes the block leaves unused: they must answer OK and change nothing
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   typedef struct {
      key_type                 min_value;
      logic [STATUS_W-1:0]     status;
      logic [COUNT_OUT_W-1:0]  entry_count;
   } rsp_beat_type;

   // mirror of the heap contents plus the responses still to come
   class heap_mirror_type;
      key_type      heap_keys [CAPACITY];
      int unsigned  heap_size = 0;
      rsp_beat_type awaited_beats [$];
      int unsigned  mismatches = 0;

      function void swap_keys(int unsigned a, int unsigned b);
         key_type t;
         t = heap_keys[a];
         heap_keys[a] = heap_keys[b];
         heap_keys[b] = t;
      endfunction

      // climb while the parent is strictly greater
      function void sift_up(int unsigned at);
         int unsigned parent;
         while (at > 0) begin
            parent = (at - 1) / 2;
            if (!(heap_keys[parent] > heap_keys[at]))
               break;
            swap_keys(at, parent);
            at = parent;
         end
      endfunction

      // sink toward the strictly smallest child, left child wins ties
      function void sift_down(int unsigned at);
         int unsigned best, lc, rc;
         forever begin
            best = at;
            lc = 2 * at + 1;
            rc = 2 * at + 2;
            if (lc < heap_size && heap_keys[lc] < heap_keys[best])
               best = lc;
            if (rc < heap_size && heap_keys[rc] < heap_keys[best])
               best = rc;
            if (best == at)
               break;
            swap_keys(at, best);
            at = best;
         end
      endfunction

      function key_type pop_root();
         key_type root;
         root = heap_keys[0];
         heap_size--;
         if (heap_size > 0) begin
            heap_keys[0] = heap_keys[heap_size];
            sift_down(0);
         end
         return root;
      endfunction

      // apply one accepted request beat and queue the response it causes
      function void note_request(logic [FUNC_W-1:0] op, key_type key,
                                 logic [POS_W-1:0] pos);
         rsp_beat_type want;
         want.min_value = '0;
         want.status = STAT_OK;
         case (op)
            FUNC_INSERT: begin
               if (heap_size >= CAPACITY) begin
                  want.status = STAT_FULL;
               end else begin
                  heap_keys[heap_size] = key;
                  heap_size++;
                  sift_up(heap_size - 1);
               end
            end
            FUNC_EXTRACT: begin
               if (heap_size == 0) begin
                  want.min_value = KEY_MAX;
                  want.status = STAT_EMPTY;
               end else begin
                  want.min_value = pop_root();
               end
            end
            FUNC_DELETE: begin
               if (pos >= heap_size) begin
                  want.status = STAT_RANGE;
               end else begin
                  heap_keys[pos] = KEY_MIN;
                  sift_up(pos);
                  void'(pop_root());
               end
            end
            FUNC_DECREASE, FUNC_INCREASE: begin
               if (pos >= heap_size) begin
                  want.status = STAT_RANGE;
               end else begin
                  heap_keys[pos] = key;
                  if (op == FUNC_DECREASE)
                     sift_up(pos);
                  else
                     sift_down(pos);
               end
            end
            default: ;
         endcase
         want.entry_count = COUNT_OUT_W'(heap_size);
         awaited_beats = {awaited_beats, want};
      endfunction

      function void check_response(key_type got_min, logic [STATUS_W-1:0] got_status,
                                   logic [COUNT_OUT_W-1:0] got_count);
         rsp_beat_type want;
         if (awaited_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response beat with none expected: ", $realtime,
                        "min %0d status %0d count %0d", got_min, got_status, got_count);
            return;
         end
         want = awaited_beats.pop_front();
         if (got_min !== want.min_value || got_status !== want.status ||
             got_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response mismatch: ", $realtime,
                        "expected min %0d status %0d count %0d, ",
                        want.min_value, want.status, want.entry_count,
                        "got min %0d status %0d count %0d",
                        got_min, got_status, got_count);
         end
      endfunction

      function int unsigned failures();
         return mismatches + awaited_beats.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [FUNC_W-1:0]      req_func;
   key_type                req_key_value;
   logic [POS_W-1:0]       req_position;
   logic                   rsp_strobe;
   key_type                rsp_min_value;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;

   heap_mirror_type tracker = new;
   bit              idle_allowed = 1'b1;

   binary_min_heap #(.CAPACITY(CAPACITY)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_key_value   (req_key_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_min_value   (rsp_min_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_response(rsp_min_value, rsp_status, rsp_entry_count);
   end

   // keys lean on extremes and a narrow band so ties are common
   function automatic key_type rand_key();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return KEY_MIN;
         1: return KEY_MAX;
         2, 3, 4: return key_type'(int'($urandom_range(0, 16)) - 8);
         default: return key_type'($urandom);
      endcase
   endfunction

   // mostly a live index, sometimes the first index past the end, else anything
   function automatic logic [POS_W-1:0] rand_pos(int unsigned size);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 8 && size > 0)
         return POS_W'($urandom_range(0, size - 1));
      if (sel == 8 && size < CAPACITY)
         return POS_W'(size);
      return POS_W'($urandom);
   endfunction

   // present one request beat and hold it until the block takes it
   task automatic issue_op(input logic [FUNC_W-1:0] op, input key_type key,
                           input logic [POS_W-1:0] pos);
      if (idle_allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= op;
      req_key_value <= key;
      req_position <= pos;
      do @(posedge clock); while (busy);
      tracker.note_request(op, key, pos);
   endtask

   task automatic mixed_op(input int unsigned insert_pct);
      int unsigned size;
      int unsigned sel;
      size = tracker.heap_size;
      sel = $urandom_range(0, 99);
      if (sel < insert_pct) begin
         issue_op(FUNC_INSERT, rand_key(), rand_pos(size));
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 40)
            issue_op(FUNC_EXTRACT, rand_key(), rand_pos(size));
         else if (sel < 60)
            issue_op(FUNC_DELETE, rand_key(), rand_pos(size));
         else if (sel < 77)
            issue_op(FUNC_DECREASE, rand_key(), rand_pos(size));
         else if (sel < 94)
            issue_op(FUNC_INCREASE, rand_key(), rand_pos(size));
         else
            issue_op(FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                     rand_key(), rand_pos(size));
      end
   endtask

   // stop sending until every predicted beat has come back, bounded
   task automatic wait_drained(input int unsigned max_cycles);
      int unsigned waited;
      waited = 0;
      start <= 1'b0;
      while (tracker.awaited_beats.size() != 0 && waited < max_cycles) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // main sequence
   initial begin
      int unsigned n;
      reset <= 1'b1;
      start <= 1'b0;
      req_func <= FUNC_INSERT;
      req_key_value <= '0;
      req_position <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty heap flags, spare codes
      issue_op(FUNC_EXTRACT, 32'sd5, 10'd0);
      issue_op(FUNC_DELETE, 32'sd0, 10'd0);
      issue_op(FUNC_DECREASE, KEY_MIN, 10'd1023);
      issue_op(FUNC_INCREASE, KEY_MAX, 10'd0);
      issue_op(FUNC_SPARE_FIRST, KEY_MIN, 10'd1023);
      issue_op(FUNC_SPARE_FIRST + 3'd1, KEY_MAX, 10'd0);
      issue_op(FUNC_SPARE_LAST, -32'sd1, 10'd512);
      // directed: extreme keys, duplicates
      issue_op(FUNC_INSERT, KEY_MAX, 10'd1023);
      issue_op(FUNC_INSERT, KEY_MIN, 10'd0);
      issue_op(FUNC_INSERT, 32'sd0, 10'd0);
      issue_op(FUNC_INSERT, -32'sd1, 10'd0);
      issue_op(FUNC_INSERT, 32'sd1, 10'd0);
      issue_op(FUNC_INSERT, KEY_MAX, 10'd0);
      // directed: index operations at both ends and just past the end
      issue_op(FUNC_DECREASE, KEY_MIN, 10'd5);
      issue_op(FUNC_INCREASE, KEY_MAX, 10'd0);
      issue_op(FUNC_DELETE, 32'sd0, 10'd5);
      issue_op(FUNC_INCREASE, 32'sd0, 10'd5);
      issue_op(FUNC_DELETE, 32'sd0, 10'd0);
      // directed: drain, then one extract too many
      repeat (5) issue_op(FUNC_EXTRACT, 32'sd0, 10'd0);

      // random mix around a small heap, with full stops now and then
      for (n = 0; n < 740; n++) begin
         if (n % 40 == 0)
            idle_allowed = ($urandom_range(0, 2) != 0);
         if (n % 200 == 199)
            wait_drained(2000);
         mixed_op(tracker.heap_size < 40 ? 45 : 30);
      end
      wait_drained(2000);

      // drain to empty back to back
      idle_allowed = 1'b0;
      while (tracker.heap_size > 0) begin
         n = $urandom_range(0, 99);
         if (n < 75)
            issue_op(FUNC_EXTRACT, rand_key(), rand_pos(tracker.heap_size));
         else
            mixed_op(0);
      end
      issue_op(FUNC_EXTRACT, rand_key(), rand_pos(0));

      wait_drained(5000);
      repeat (80) @(posedge clock);
      if (tracker.failures() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
